[rtl/bol_pkg.sv]
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and constants of the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned KindW    = 3;
  localparam int unsigned ValW     = 32;
  localparam int unsigned PosW     = 5;
  localparam int unsigned StatW    = 3;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [KindW-1:0] {
    KIND_HEAD = 3'd0,
    KIND_TAIL = 3'd1,
    KIND_AT   = 3'd2,
    KIND_DEL  = 3'd3,
    KIND_DUMP = 3'd4
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } fsm_e;

  typedef struct packed {
    cell_op_e               op;
    logic [CntW-1:0]        idx;
    logic [CntW-1:0]        cnt;
    logic signed [ValW-1:0] value;
  } cell_ctrl_t;

endpackage

[rtl/bounded_ordered_list_engine_top.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// Ordered list of up to CAPACITY signed values kept in a shifting cell chain.
// ----------------------------------------------------------------------------
// Insert (head, tail, position) and delete each give one result; a request is
// taken whenever the output register is free or being emptied. A dump first
// enters its dump state, then gives one element per cycle while the output
// register is free, out of the head cell while the chain rotates by one, so
// the list is back in order once the last element leaves. No new request is
// taken during a dump. Delete looks for the first match through a priority
// chain that runs across all cells in the same cycle.
module bounded_ordered_list_engine_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bol_pkg::KindW-1:0]         kind_i,
  input  logic signed [bol_pkg::ValW-1:0]   value_i,
  input  logic [bol_pkg::PosW-1:0]          position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bol_pkg::StatW-1:0]         status_o,
  output logic [bol_pkg::CountW-1:0]        count_o,
  output logic signed [bol_pkg::ValW-1:0]   element_o,
  output logic                              last_o
);
  import bol_pkg::*;

  fsm_e                   state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        rem_q, rem_d;
  logic                   ov_q, ov_d;
  status_e                st_q, st_d;
  logic [CountW-1:0]      count_q, count_d;
  logic signed [ValW-1:0] el_q, el_d;
  logic                   last_q, last_d;

  cell_ctrl_t             ctrl;
  logic signed [ValW-1:0] data   [CAPACITY];
  logic                   hit    [CAPACITY+1];
  logic                   accept;
  logic                   slot_free;
  logic                   pos_bad;
  logic                   full;

  assign slot_free  = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_bad    = CmpW'(position_i) > CmpW'(cnt_q);
  assign full       = cnt_q == CntW'(CAPACITY);

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid
      assign left = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = data[i];
    end else begin : g_inner
      assign right = data[i+1];
    end
    bol_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CntW'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .head_i  (data[0]),
      .hit_i   (hit[i]),
      .data_o  (data[i]),
      .hit_o   (hit[i+1])
    );
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    ov_d       = ov_q && !out_ready_i;
    st_d       = st_q;
    count_d    = count_q;
    el_d       = el_q;
    last_d     = last_q;
    ctrl.op    = OP_HOLD;
    ctrl.idx   = '0;
    ctrl.cnt   = cnt_q;
    ctrl.value = value_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ov_d   = 1'b1;
          st_d   = ST_OK;
          el_d   = '0;
          last_d = 1'b1;
          case (kind_e'(kind_i))
            KIND_HEAD, KIND_TAIL, KIND_AT: begin
              if (kind_e'(kind_i) == KIND_AT && pos_bad) begin
                st_d = ST_BADPOS;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                ctrl.op = OP_INS;
                case (kind_e'(kind_i))
                  KIND_HEAD: ctrl.idx = '0;
                  KIND_TAIL: ctrl.idx = cnt_q;
                  default:   ctrl.idx = CntW'(position_i);
                endcase
                cnt_d = cnt_q + CntW'(1);
              end
            end
            KIND_DEL: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else if (!hit[CAPACITY]) begin
                st_d = ST_NOTFOUND;
              end else begin
                ctrl.op = OP_DEL;
                cnt_d   = cnt_q - CntW'(1);
              end
            end
            KIND_DUMP: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                ov_d    = 1'b0;
                state_d = S_DUMP;
                rem_d   = cnt_q;
              end
            end
            default: begin
              st_d = ST_OK;
            end
          endcase
          count_d = CountW'(cnt_d);
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          st_d    = ST_OK;
          el_d    = data[0];
          last_d  = rem_q == CntW'(1);
          count_d = CountW'(cnt_q);
          ctrl.op = OP_ROT;
          rem_d   = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    count_q <= count_d;
    el_q    <= el_d;
    last_q  <= last_d;
  end

  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign count_o     = count_q;
  assign element_o   = el_q;
  assign last_o      = last_q;

endmodule

[rtl/bol_cell.sv]
// ----------------------------------------------------------------------------
// bol_cell
// One slot of the list chain: holds an element and shifts it to or from
// its neighbors on insert, delete and dump rotation.
// ----------------------------------------------------------------------------
module bol_cell (
  input  logic                            clk_i,
  input  logic [bol_pkg::CntW-1:0]        idx_i,
  input  bol_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [bol_pkg::ValW-1:0] left_i,
  input  logic signed [bol_pkg::ValW-1:0] right_i,
  input  logic signed [bol_pkg::ValW-1:0] head_i,
  input  logic                            hit_i,
  output logic signed [bol_pkg::ValW-1:0] data_o,
  output logic                            hit_o
);
  import bol_pkg::*;

  logic signed [ValW-1:0] data_q, data_d;
  logic                   occupied;
  logic                   match;

  assign occupied = idx_i < ctrl_i.cnt;
  assign match    = occupied && (data_q == ctrl_i.value);
  // first match upstream or here: everything from it onward moves toward the head
  assign hit_o    = hit_i | match;
  assign data_o   = data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_INS: begin
        if (idx_i == ctrl_i.idx) begin
          data_d = ctrl_i.value;
        end else if (idx_i > ctrl_i.idx && idx_i <= ctrl_i.cnt) begin
          data_d = left_i;
        end
      end
      OP_DEL: begin
        if (hit_o) begin
          data_d = right_i;
        end
      end
      OP_ROT: begin
        // head wraps around to the current tail slot
        if (idx_i == ctrl_i.cnt - CntW'(1)) begin
          data_d = head_i;
        end else begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[rtl/bol_checker.sv]
// ----------------------------------------------------------------------------
// bol_checker
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module bol_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [bol_pkg::StatW-1:0]         status_o,
  input logic [bol_pkg::CountW-1:0]        count_o,
  input logic signed [bol_pkg::ValW-1:0]   element_o,
  input logic                              last_o
);
  import bol_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(count_o) && $stable(element_o) && $stable(last_o))
    else $error("stalled result changed");

  // any error status ends its request
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o)
    else $error("error status without last");

  // a nonzero element only comes with an OK status
  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && element_o != '0 |-> status_o == ST_OK)
    else $error("element with error status");

  // no new request while a dump is still going
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_o)
    else $error("request taken mid dump");

endmodule

bind bounded_ordered_list_engine_top bol_checker u_bol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .count_o     (count_o),
  .element_o   (element_o),
  .last_o      (last_o)
);

[sim/bounded_ordered_list_engine_top_test.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top_test
// Drives list operations through the request channel, keeps a shadow copy of
// the list to predict every status, count and dumped element, and checks each
// result in order while both sides stall at random.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_test;
  import bol_pkg::*;

  localparam int unsigned     WatchdogLimit = 3000;
  localparam int unsigned     LongHold      = 120;
  localparam int unsigned     TailCycles    = 40;
  localparam logic [KindW-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KindW-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        position;
  } list_op_t;

  typedef struct packed {
    logic [StatW-1:0]       status;
    logic [CountW-1:0]      count;
    logic signed [ValW-1:0] element;
    logic                   last;
  } list_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic         offer_valid = 1'b0;
  list_op_t     offer       = '0;
  logic         in_ready_o;
  logic         out_valid_o;
  logic         out_ready   = 1'b0;
  logic [StatW-1:0]       status_o;
  logic [CountW-1:0]      count_o;
  logic signed [ValW-1:0] element_o;
  logic                   last_o;

  bounded_ordered_list_engine_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (offer_valid),
    .in_ready_o  (in_ready_o),
    .kind_i      (offer.kind),
    .value_i     (offer.value),
    .position_i  (offer.position),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .status_o    (status_o),
    .count_o     (count_o),
    .element_o   (element_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  list_op_t     op_queue[$];
  list_report_t expected_reports[$];

  logic signed [ValW-1:0] shadow_cells [CAPACITY];
  int unsigned            shadow_len = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned stall_cycles   = 0;
  int unsigned segment_no     = 0;

  int unsigned errors          = 0;
  int unsigned reqs_taken      = 0;
  int unsigned reports_checked = 0;
  int unsigned dumps_seen      = 0;
  int unsigned full_hits       = 0;
  int unsigned deletes_hit     = 0;

  function automatic void push_report(logic [StatW-1:0] st, logic signed [ValW-1:0] elem,
                                      logic fin);
    list_report_t r;
    r.status  = st;
    r.count   = shadow_len[CountW-1:0];
    r.element = elem;
    r.last    = fin;
    expected_reports.push_back(r);
  endfunction

  // insert with shift toward the tail; full is refused
  function automatic logic [StatW-1:0] shadow_insert(int unsigned idx,
                                                     logic signed [ValW-1:0] v);
    if (shadow_len >= CAPACITY) begin
      full_hits++;
      return ST_FULL;
    end
    for (int unsigned i = shadow_len; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[idx] = v;
    shadow_len++;
    return ST_OK;
  endfunction

  function automatic void apply_list_op(list_op_t op);
    logic [StatW-1:0] st;
    int unsigned      hit;
    st = ST_OK;
    case (op.kind)
      KIND_HEAD: st = shadow_insert(0, op.value);
      KIND_TAIL: st = shadow_insert(shadow_len, op.value);
      KIND_AT: begin
        // a bad position wins over a full list
        if (op.position > shadow_len) st = ST_BADPOS;
        else st = shadow_insert(op.position, op.value);
      end
      KIND_DEL: begin
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else begin
          hit = shadow_len;
          for (int unsigned i = 0; i < shadow_len; i++) begin
            if (hit == shadow_len && shadow_cells[i] == op.value) hit = i;
          end
          if (hit == shadow_len) begin
            st = ST_NOTFOUND;
          end else begin
            for (int unsigned i = hit; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
            shadow_len--;
            deletes_hit++;
          end
        end
      end
      KIND_DUMP: begin
        dumps_seen++;
        if (shadow_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < shadow_len; i++) begin
            push_report(ST_OK, shadow_cells[i], (i + 1 == shadow_len));
          end
          return;
        end
      end
      default: st = ST_OK;
    endcase
    push_report(st, '0, 1'b1);
  endfunction

  function automatic list_op_t make_op(logic [KindW-1:0] k, logic signed [ValW-1:0] v,
                                       logic [PosW-1:0] p);
    list_op_t op;
    op.kind     = k;
    op.value    = v;
    op.position = p;
    return op;
  endfunction

  // small pool so deletes find their target often
  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned s;
    if ($urandom_range(99) >= 60) return $urandom;
    s = $urandom_range(8);
    case (s)
      6:       return 32'sh8000_0000;
      7:       return 32'sh7fff_ffff;
      8:       return -32'sd1;
      default: return s;
    endcase
  endfunction

  // alternating segments lean toward filling or draining the list
  task automatic queue_random_ops(int unsigned n);
    int unsigned r;
    int unsigned bias;
    logic [KindW-1:0] k;
    logic [PosW-1:0]  p;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 30 == 0) segment_no++;
      bias = segment_no[0] ? 80 : 25;
      r = $urandom_range(99);
      if (r < 3) begin
        k = $urandom_range(KIND_SPARE_HI, KIND_SPARE_LO);
      end else if (r < 12) begin
        k = KIND_DUMP;
      end else if ($urandom_range(99) < bias) begin
        case ($urandom_range(2))
          0:       k = KIND_HEAD;
          1:       k = KIND_TAIL;
          default: k = KIND_AT;
        endcase
      end else begin
        k = KIND_DEL;
      end
      p = ($urandom_range(99) < 75) ? $urandom_range(CAPACITY) : $urandom_range(31);
      op_queue.push_back(make_op(k, pick_value(), p));
    end
  endtask

  task automatic wait_drained();
    while (op_queue.size() != 0 || offer_valid || expected_reports.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // request side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      offer_valid <= 1'b0;
    end else begin
      if (offer_valid && in_ready_o) begin
        apply_list_op(offer);
        reqs_taken++;
      end
      if (!offer_valid || in_ready_o) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offer       <= op_queue.pop_front();
          offer_valid <= 1'b1;
        end else begin
          offer_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    list_report_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0h count %0h element %0h last %0b",
                   $time, status_o, count_o, element_o, last_o);
        end else begin
          want = expected_reports.pop_front();
          check_field("status", want.status, status_o);
          check_field("count", want.count, count_o);
          check_field("element", want.element, element_o);
          check_field("last", want.last, last_o);
          reports_checked++;
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left      <= LongHold;
        out_ready      <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((offer_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
        $display("bounded_ordered_list_engine_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    tx_idle_pct = 26;
    rx_idle_pct = 83;

    // empty list corners, bad positions, extremes, then fill to capacity
    op_queue.push_back(make_op(KIND_DUMP, 0, 0));
    op_queue.push_back(make_op(KIND_DEL, 7, 0));
    op_queue.push_back(make_op(KIND_SPARE_LO, 32'sh7fff_ffff, 5'd31));
    op_queue.push_back(make_op(KIND_AT, 9, 1));
    op_queue.push_back(make_op(KIND_AT, -32'sd1, 0));
    op_queue.push_back(make_op(KIND_HEAD, 32'sh8000_0000, 0));
    op_queue.push_back(make_op(KIND_TAIL, 32'sh7fff_ffff, 0));
    op_queue.push_back(make_op(KIND_AT, 32'sh5555_5555, 3));
    op_queue.push_back(make_op(KIND_DEL, 32'sh1234_5678, 0));
    for (int unsigned i = 0; i < 12; i++) begin
      case (i % 3)
        0:       op_queue.push_back(make_op(KIND_HEAD, 32'sh1000 + i, 0));
        1:       op_queue.push_back(make_op(KIND_TAIL, 32'sh1000 + i, 0));
        default: op_queue.push_back(make_op(KIND_AT, 32'sh1000 + i, i % 4));
      endcase
    end
    op_queue.push_back(make_op(KIND_HEAD, 1, 0));
    op_queue.push_back(make_op(KIND_AT, 2, 16));
    op_queue.push_back(make_op(KIND_AT, 3, 17));
    op_queue.push_back(make_op(KIND_DUMP, 0, 0));
    op_queue.push_back(make_op(KIND_DEL, 32'sh7fff_ffff, 0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_random_ops(160);
    wait_drained();

    tx_idle_pct = 83;
    rx_idle_pct = 26;
    queue_random_ops(160);
    wait_drained();

    // no idling; a long receiver stall backs the engine up into the sender
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_ops(75);
    long_hold_req = 1'b1;
    wait_drained();
    queue_random_ops(75);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    $display("ran %0d requests (%0d dumps, %0d full refusals, %0d deletes found)",
             reqs_taken, dumps_seen, full_hits, deletes_hit);
    $display("checked %0d results, %0d errors", reports_checked, errors);
    if (errors == 0) begin
      $display("bounded_ordered_list_engine_top: match");
    end else begin
      $display("bounded_ordered_list_engine_top: mismatch");
    end
    $finish;
  end

endmodule
